FILE: rtl/rtsq_pkg.sv
// Shared types and constants of the retransmit slot queue.
// Holds the payload structs, the opcode and result codes and the slot memory entry.
// No dependencies.
package rtsq_pkg;

  localparam int unsigned QueueDepth    = 32;
  localparam int unsigned PacketRefBits = 16;
  localparam int unsigned MaxResults    = 32;
  localparam int unsigned SlotW         = $clog2(QueueDepth);
  localparam int unsigned CountW        = $clog2(QueueDepth + 1);
  localparam int unsigned HitW          = $clog2(MaxResults + 1);
  localparam int unsigned AddrW         = 3;

  // Register indexes, taken from paddr bit 2.
  localparam logic RegRetryBase  = 1'b0;
  localparam logic RegRetryLimit = 1'b1;

  localparam logic [15:0] RetryBaseReset  = 16'd5000;
  localparam logic [3:0]  RetryLimitReset = 4'd5;

  typedef enum logic [1:0] {
    OpPush   = 2'd0,
    OpScan   = 2'd1,
    OpReport = 2'd2,
    OpNone   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KindPushed    = 3'd0,
    KindFull      = 3'd1,
    KindSendReq   = 3'd2,
    KindScanEmpty = 3'd3,
    KindFreed     = 3'd4,
    KindResched   = 3'd5,
    KindDropped   = 3'd6,
    KindBadSlot   = 3'd7
  } result_kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StPush,
    StScan,
    StRepRd,
    StRepUpd
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] packet_ref;
    logic [31:0] now_ms;
    logic [4:0]  slot_index;
    logic        send_ok;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [4:0]   result_slot;
    logic [15:0]  result_packet;
    logic [5:0]   occupied_count;
    logic         last_result;
  } out_item_t;

  typedef struct packed {
    logic [15:0] retry_base_ms;
    logic [3:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0]               retries;
    logic [31:0]              due_time;
    logic [PacketRefBits-1:0] packet;
  } slot_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    slot_entry_t      wr_data;
  } mem_req_t;

  typedef struct packed {
    result_kind_e kind;
    logic         release_slot;
    slot_entry_t  entry;
  } verdict_t;

endpackage

FILE: rtl/rtsq_cfg.sv
// Configuration registers of the retransmit slot queue behind an APB-style port.
// Depends on rtsq_pkg.
module rtsq_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rtsq_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rtsq_pkg::cfg_t             cfg_o
);

  rtsq_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        rtsq_pkg::RegRetryBase:  cfg_d.retry_base_ms = pwdata[15:0];
        rtsq_pkg::RegRetryLimit: cfg_d.retry_limit   = pwdata[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rtsq_pkg::RegRetryBase:  prdata = {16'b0, cfg_q.retry_base_ms};
      rtsq_pkg::RegRetryLimit: prdata = {28'b0, cfg_q.retry_limit};
      default: prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_base_ms <= rtsq_pkg::RetryBaseReset;
      cfg_q.retry_limit   <= rtsq_pkg::RetryLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rtsq_slot_mem.sv
// Slot memory: retry count, due time and packet reference of every slot.
// One write and one read port, registered read data. Depends on rtsq_pkg.
module rtsq_slot_mem (
  input  logic                  clk_i,
  input  rtsq_pkg::mem_req_t    req_i,
  output rtsq_pkg::slot_entry_t rdata_o
);

  rtsq_pkg::slot_entry_t mem_q [rtsq_pkg::QueueDepth];
  rtsq_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rtsq_retry.sv
// Verdict logic for a send report: frees, drops or reschedules a slot entry.
// Computes the exponential backoff due time. Depends on rtsq_pkg.
module rtsq_retry (
  input  rtsq_pkg::slot_entry_t entry_i,
  input  logic [31:0]           now_i,
  input  logic                  send_ok_i,
  input  rtsq_pkg::cfg_t        cfg_i,
  output rtsq_pkg::verdict_t    verdict_o
);

  logic [3:0]  retries_next;
  logic [31:0] delay;

  // The retry count saturates instead of wrapping.
  assign retries_next = (entry_i.retries == 4'hF) ? 4'hF : entry_i.retries + 4'd1;
  assign delay        = {16'b0, cfg_i.retry_base_ms} << retries_next;

  always_comb begin
    verdict_o.entry.retries  = retries_next;
    verdict_o.entry.due_time = now_i + delay;
    verdict_o.entry.packet   = entry_i.packet;
    if (send_ok_i) begin
      verdict_o.kind         = rtsq_pkg::KindFreed;
      verdict_o.release_slot = 1'b1;
    end else if (retries_next >= cfg_i.retry_limit) begin
      verdict_o.kind         = rtsq_pkg::KindDropped;
      verdict_o.release_slot = 1'b1;
    end else begin
      verdict_o.kind         = rtsq_pkg::KindResched;
      verdict_o.release_slot = 1'b0;
    end
  end

endmodule

FILE: rtl/rtsq_ctrl.sv
// Sequencer of the retransmit slot queue: valid bits, occupancy, slot walks and
// the output register. Drives the slot memory. Depends on rtsq_pkg and rtsq_retry.
module rtsq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rtsq_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rtsq_pkg::out_item_t   out_data_o,
  input  rtsq_pkg::cfg_t        cfg_i,
  output rtsq_pkg::mem_req_t    mem_req_o,
  input  rtsq_pkg::slot_entry_t mem_rdata_i
);

  localparam logic [rtsq_pkg::SlotW-1:0] LastSlot =
    rtsq_pkg::SlotW'(rtsq_pkg::QueueDepth - 1);

  rtsq_pkg::state_e    state_q, state_d;
  rtsq_pkg::in_item_t  item_q, item_d;
  rtsq_pkg::out_item_t out_q, out_d;
  rtsq_pkg::out_item_t emit_item;
  rtsq_pkg::verdict_t  verdict;

  logic                               out_vld_q, out_vld_d;
  logic [rtsq_pkg::QueueDepth-1:0]    valid_q, valid_d;
  logic [rtsq_pkg::CountW-1:0]        count_q, count_d;
  logic [rtsq_pkg::SlotW-1:0]         ptr_q, ptr_d;
  logic                               issued_all_q, issued_all_d;
  logic                               ev_vld_q, ev_vld_d;
  logic [rtsq_pkg::SlotW-1:0]         ev_slot_q, ev_slot_d;
  logic                               held_vld_q, held_vld_d;
  logic [rtsq_pkg::SlotW-1:0]         held_slot_q, held_slot_d;
  logic [rtsq_pkg::PacketRefBits-1:0] held_pkt_q, held_pkt_d;
  logic [rtsq_pkg::HitW-1:0]          hits_q, hits_d;

  logic                               accept;
  logic                               emit;
  logic                               out_free;
  logic [rtsq_pkg::SlotW-1:0]         idx_addr;
  logic                               bad_slot;
  logic                               push_free;
  logic                               push_last;
  logic                               hit;
  logic                               stall;
  logic                               scan_drained;

  assign in_ready_o   = (state_q == rtsq_pkg::StIdle);
  assign accept       = in_valid_i && in_ready_o;
  assign out_free     = !out_vld_q || out_ready_i;
  assign idx_addr     = rtsq_pkg::SlotW'(item_q.slot_index);
  assign bad_slot     = (32'(item_q.slot_index) >= 32'(rtsq_pkg::QueueDepth)) ||
                        !valid_q[idx_addr];
  assign push_free    = !valid_q[ptr_q];
  assign push_last    = (ptr_q == LastSlot);
  assign hit          = ev_vld_q && valid_q[ev_slot_q] &&
                        (mem_rdata_i.due_time <= item_q.now_ms) &&
                        (hits_q != rtsq_pkg::HitW'(rtsq_pkg::MaxResults));
  // A second due slot cannot move into the held register while the held one
  // still has nowhere to go.
  assign stall        = hit && held_vld_q && !out_free;
  assign scan_drained = issued_all_q && !ev_vld_q;

  rtsq_retry u_retry (
    .entry_i   (mem_rdata_i),
    .now_i     (item_q.now_ms),
    .send_ok_i (item_q.send_ok),
    .cfg_i     (cfg_i),
    .verdict_o (verdict)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtsq_pkg::StIdle: begin
        if (accept) begin
          unique case (in_data_i.opcode)
            rtsq_pkg::OpPush:   state_d = rtsq_pkg::StPush;
            rtsq_pkg::OpScan:   state_d = rtsq_pkg::StScan;
            rtsq_pkg::OpReport: state_d = rtsq_pkg::StRepRd;
            rtsq_pkg::OpNone:   state_d = rtsq_pkg::StIdle;
            default:            state_d = rtsq_pkg::StIdle;
          endcase
        end
      end
      rtsq_pkg::StPush: begin
        if (out_free && (push_free || push_last)) begin
          state_d = rtsq_pkg::StIdle;
        end
      end
      rtsq_pkg::StScan: begin
        if (scan_drained && out_free) begin
          state_d = rtsq_pkg::StIdle;
        end
      end
      rtsq_pkg::StRepRd: begin
        if (!bad_slot) begin
          state_d = rtsq_pkg::StRepUpd;
        end else if (out_free) begin
          state_d = rtsq_pkg::StIdle;
        end
      end
      rtsq_pkg::StRepUpd: begin
        if (out_free) begin
          state_d = rtsq_pkg::StIdle;
        end
      end
      default: state_d = rtsq_pkg::StIdle;
    endcase
  end

  // Datapath control.
  always_comb begin
    item_d       = accept ? in_data_i : item_q;
    valid_d      = valid_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    issued_all_d = issued_all_q;
    ev_vld_d     = ev_vld_q;
    ev_slot_d    = ev_slot_q;
    held_vld_d   = held_vld_q;
    held_slot_d  = held_slot_q;
    held_pkt_d   = held_pkt_q;
    hits_d       = hits_q;
    mem_req_o    = '0;
    emit         = 1'b0;
    emit_item    = '0;
    emit_item.occupied_count = 6'(count_q);
    emit_item.last_result    = 1'b1;

    unique case (state_q)
      rtsq_pkg::StIdle: begin
        ptr_d        = '0;
        issued_all_d = 1'b0;
        ev_vld_d     = 1'b0;
        held_vld_d   = 1'b0;
        hits_d       = '0;
      end
      rtsq_pkg::StPush: begin
        if (push_free) begin
          if (out_free) begin
            mem_req_o.wr_en            = 1'b1;
            mem_req_o.wr_addr          = ptr_q;
            mem_req_o.wr_data.retries  = 4'd0;
            mem_req_o.wr_data.due_time = item_q.now_ms;
            mem_req_o.wr_data.packet   = rtsq_pkg::PacketRefBits'(item_q.packet_ref);
            valid_d[ptr_q]             = 1'b1;
            count_d                    = count_q + 1'b1;
            emit                       = 1'b1;
            emit_item.result_kind      = rtsq_pkg::KindPushed;
            emit_item.result_slot      = 5'(ptr_q);
            emit_item.result_packet    =
              16'(rtsq_pkg::PacketRefBits'(item_q.packet_ref));
            emit_item.occupied_count   = 6'(count_q + 1'b1);
          end
        end else if (push_last) begin
          if (out_free) begin
            emit                  = 1'b1;
            emit_item.result_kind = rtsq_pkg::KindFull;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      rtsq_pkg::StScan: begin
        if (!stall) begin
          mem_req_o.rd_en   = !issued_all_q;
          mem_req_o.rd_addr = ptr_q;
          if (!issued_all_q) begin
            ptr_d        = ptr_q + 1'b1;
            issued_all_d = push_last;
          end
          ev_vld_d  = !issued_all_q;
          ev_slot_d = ptr_q;
          if (hit) begin
            if (held_vld_q) begin
              emit                    = 1'b1;
              emit_item.result_kind   = rtsq_pkg::KindSendReq;
              emit_item.result_slot   = 5'(held_slot_q);
              emit_item.result_packet = 16'(held_pkt_q);
              emit_item.last_result   = 1'b0;
            end
            held_vld_d  = 1'b1;
            held_slot_d = ev_slot_q;
            held_pkt_d  = mem_rdata_i.packet;
            hits_d      = hits_q + 1'b1;
          end
        end
        // With every slot looked at, the held request is the last one.
        if (scan_drained && out_free) begin
          emit = 1'b1;
          if (held_vld_q) begin
            emit_item.result_kind   = rtsq_pkg::KindSendReq;
            emit_item.result_slot   = 5'(held_slot_q);
            emit_item.result_packet = 16'(held_pkt_q);
          end else begin
            emit_item.result_kind = rtsq_pkg::KindScanEmpty;
          end
        end
      end
      rtsq_pkg::StRepRd: begin
        if (bad_slot) begin
          if (out_free) begin
            emit                  = 1'b1;
            emit_item.result_kind = rtsq_pkg::KindBadSlot;
            emit_item.result_slot = item_q.slot_index;
          end
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = idx_addr;
        end
      end
      rtsq_pkg::StRepUpd: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_item.result_kind   = verdict.kind;
          emit_item.result_slot   = item_q.slot_index;
          emit_item.result_packet = 16'(mem_rdata_i.packet);
          if (verdict.release_slot) begin
            valid_d[idx_addr]        = 1'b0;
            count_d                  = count_q - 1'b1;
            emit_item.occupied_count = 6'(count_q - 1'b1);
          end else begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = idx_addr;
            mem_req_o.wr_data = verdict.entry;
          end
        end
      end
      default: begin
        ptr_d = '0;
      end
    endcase

    if (emit) begin
      out_vld_d = 1'b1;
      out_d     = emit_item;
    end else begin
      out_vld_d = out_vld_q && !out_ready_i;
      out_d     = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rtsq_pkg::StIdle;
      out_vld_q    <= 1'b0;
      valid_q      <= '0;
      count_q      <= '0;
      ptr_q        <= '0;
      issued_all_q <= 1'b0;
      ev_vld_q     <= 1'b0;
      held_vld_q   <= 1'b0;
      hits_q       <= '0;
    end else begin
      state_q      <= state_d;
      out_vld_q    <= out_vld_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      issued_all_q <= issued_all_d;
      ev_vld_q     <= ev_vld_d;
      held_vld_q   <= held_vld_d;
      hits_q       <= hits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    out_q       <= out_d;
    ev_slot_q   <= ev_slot_d;
    held_slot_q <= held_slot_d;
    held_pkt_q  <= held_pkt_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/retry_tx_slot_queue.sv
// Top level of the retransmit slot queue with exponential backoff.
// Instantiates rtsq_cfg, rtsq_ctrl and rtsq_slot_mem; depends on rtsq_pkg.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ------------------------------
//   in        in_valid_i / in_ready_o      rtsq_pkg::in_item_t  in_data_i
//   out       out_valid_o / out_ready_i    rtsq_pkg::out_item_t out_data_o
//   config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// The block takes one transaction at a time; in_ready_o is high only while it
// is idle. A push walks the valid bits one slot per cycle. A scan reads the
// slot memory one slot per cycle through its single read port, but holds
// while a due slot waits behind a stalled output register. A report on a
// valid slot reads it, then updates it, writing back a rescheduled entry; a
// bad slot gets no read. An unused opcode is accepted and yields no result.
// Reset clears the valid bits and the occupancy count at once; the slot
// memory is never cleared since the data of an invalid slot is never used.
// A stalled output register holds the sequencer; one result can wait in the
// output register while the next is being found.
module retry_tx_slot_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rtsq_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rtsq_pkg::out_item_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rtsq_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  rtsq_pkg::cfg_t        cfg;
  rtsq_pkg::mem_req_t    mem_req;
  rtsq_pkg::slot_entry_t mem_rdata;

  // Register file, to be written only while the queue is idle (not enforced).
  rtsq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer with valid bits, occupancy and the output register.
  rtsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_i       (cfg),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Per-slot retry count, due time and packet reference.
  rtsq_slot_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the retransmit slot queue (retry_tx_slot_queue).
// Drives pushes, scans and radio reports, keeps its own copy of the slot table and
// checks every result; depends on rtsq_pkg and the RTL of retry_tx_slot_queue.
module testbench;
  import rtsq_pkg::*;

  // Cycles the block may still spend on a transaction that yields no result
  // (an unused opcode), plus some slack. A scan walks every slot once.
  localparam int unsigned DrainCycles = QueueDepth + 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [AddrW-1:0]     paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic                 in_ready;
  logic                 out_valid;
  out_item_t            out_data;
  logic [31:0]          prdata;
  logic                 pready;

  // Our own view of the slot table and of the backoff registers.
  bit                   tbl_valid   [QueueDepth];
  logic [3:0]           tbl_retries [QueueDepth];
  logic [31:0]          tbl_due     [QueueDepth];
  logic [15:0]          tbl_packet  [QueueDepth];
  logic [15:0]          cur_base  = RetryBaseReset;
  logic [3:0]           cur_limit = RetryLimitReset;

  // Results the block owes us, oldest first.
  out_item_t            slot_outcomes[$];
  int unsigned          mismatches = 0;
  int unsigned          ready_hold = 0;
  // When set, neither side inserts idle cycles.
  bit                   steady = 1'b0;
  // Running millisecond clock used by the random traffic.
  logic [31:0]          wall_ms = '0;

  retry_tx_slot_queue uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls at random. Changes land on the falling edge so
  // that the block sees a settled out_ready at the next rising edge.
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= pick_gap();
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Every result transaction is matched against the oldest outstanding one.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (slot_outcomes.size() == 0) begin
        $error("result with nothing outstanding: kind %0d slot %0d", out_data.result_kind,
               out_data.result_slot);
        mismatches++;
      end else begin
        want = slot_outcomes.pop_front();
        compare_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
        compare_field("result_slot", 32'(want.result_slot), 32'(out_data.result_slot));
        compare_field("result_packet", 32'(want.result_packet), 32'(out_data.result_packet));
        compare_field("occupied_count", 32'(want.occupied_count),
                      32'(out_data.occupied_count));
        compare_field("last_result", 32'(want.last_result), 32'(out_data.last_result));
      end
    end
  end

  // Applies one accepted transaction to our slot table and queues the
  // results that the block has to produce for it.
  task automatic step_slot_table(input in_item_t item);
    out_item_t   burst[$];
    out_item_t   res;
    int unsigned occ;
    logic [3:0]  tries;
    logic [4:0]  idx;
    bit          placed;
    res    = '0;
    idx    = item.slot_index;
    placed = 1'b0;
    case (item.opcode)
      OpPush: begin
        // The lowest free slot takes the packet, due at once.
        for (int i = 0; i < QueueDepth && !placed; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i]       = 1'b1;
            tbl_retries[i]     = '0;
            tbl_due[i]         = item.now_ms;
            tbl_packet[i]      = item.packet_ref;
            res.result_kind    = KindPushed;
            res.result_slot    = 5'(i);
            res.result_packet  = item.packet_ref;
            placed             = 1'b1;
            burst.push_back(res);
          end
        end
        if (!placed) begin
          res.result_kind = KindFull;
          burst.push_back(res);
        end
      end
      OpScan: begin
        // Plain unsigned compare: a due time past a wrap of now is not due.
        for (int i = 0; i < QueueDepth && burst.size() < MaxResults; i++) begin
          if (tbl_valid[i] && tbl_due[i] <= item.now_ms) begin
            res.result_kind   = KindSendReq;
            res.result_slot   = 5'(i);
            res.result_packet = tbl_packet[i];
            burst.push_back(res);
          end
        end
        if (burst.size() == 0) begin
          res.result_kind = KindScanEmpty;
          burst.push_back(res);
        end
      end
      OpReport: begin
        res.result_slot = idx;
        if (!tbl_valid[idx]) begin
          res.result_kind = KindBadSlot;
        end else begin
          res.result_packet = tbl_packet[idx];
          if (item.send_ok) begin
            tbl_valid[idx]  = 1'b0;
            res.result_kind = KindFreed;
          end else begin
            tries = tbl_retries[idx];
            if (tries != 4'hF) tries++;
            tbl_retries[idx] = tries;
            if (tries >= cur_limit) begin
              tbl_valid[idx]  = 1'b0;
              res.result_kind = KindDropped;
            end else begin
              // Backoff doubles per failure; the sum wraps at 32 bits.
              tbl_due[idx]    = item.now_ms + (32'(cur_base) << tries);
              res.result_kind = KindResched;
            end
          end
        end
        burst.push_back(res);
      end
      default: begin
        // An unused opcode changes nothing and owes no result.
      end
    endcase
    occ = 0;
    foreach (tbl_valid[i]) if (tbl_valid[i]) occ++;
    foreach (burst[k]) begin
      burst[k].occupied_count = 6'(occ);
      burst[k].last_result    = (k == burst.size() - 1);
      slot_outcomes.push_back(burst[k]);
    end
  endtask

  // Offers one transaction after a random gap and holds it until accepted.
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    step_slot_table(item);
  endtask

  function automatic in_item_t make_item(input opcode_e op, input logic [15:0] pref,
                                         input logic [31:0] now, input logic [4:0] idx,
                                         input bit ok);
    in_item_t item;
    item.opcode     = op;
    item.packet_ref = pref;
    item.now_ms     = now;
    item.slot_index = idx;
    item.send_ok    = ok;
    return item;
  endfunction

  // Stops offering work and waits until every owed result has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (slot_outcomes.size() != 0) @(posedge clk);
  endtask

  // Brings the block to rest: nothing owed, and no silent transaction in flight.
  task automatic settle_block();
    pause_until_drained();
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == RegRetryBase) cur_base = value[15:0];
    else cur_limit = value[3:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reprograms both backoff registers while the block is at rest. The unused
  // upper bits of the write data carry noise, which the registers must drop.
  task automatic set_backoff(input logic [15:0] base, input logic [3:0] limit);
    settle_block();
    write_reg(RegRetryBase, {16'($urandom()), base});
    write_reg(RegRetryLimit, {28'($urandom()), limit});
  endtask

  // Directed checks under the reset values of the backoff registers.
  task automatic test_reset_defaults();
    send_item(make_item(OpScan, 16'h0000, 32'h0000_0000, 5'd0, 1'b0));    // empty scan
    send_item(make_item(OpReport, 16'h0000, 32'h0000_0000, 5'd0, 1'b1));  // bad slot
    send_item(make_item(OpReport, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b0)); // bad slot
    send_item(make_item(OpNone, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b1));   // ignored
    send_item(make_item(OpPush, 16'h0000, 32'h0000_0000, 5'd0, 1'b0));
    send_item(make_item(OpPush, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b1));
    send_item(make_item(OpScan, 16'h0000, 32'h0000_0000, 5'd0, 1'b0));
    send_item(make_item(OpScan, 16'h0000, 32'hFFFF_FFFF, 5'd0, 1'b0));
    // A failure near the top of the time range reschedules past the wrap.
    send_item(make_item(OpReport, 16'h0000, 32'hFFFF_FFF0, 5'd1, 1'b0));
    send_item(make_item(OpScan, 16'h0000, 32'd100, 5'd0, 1'b0));
    send_item(make_item(OpScan, 16'h0000, 32'd9984, 5'd0, 1'b0));
    send_item(make_item(OpReport, 16'h0000, 32'd9990, 5'd0, 1'b1));       // freed
    send_item(make_item(OpPush, 16'h1234, 32'd5, 5'd0, 1'b0));
    // Five failures in a row reach the default limit and drop the packet.
    repeat (5) send_item(make_item(OpReport, 16'h0000, 32'd20000, 5'd0, 1'b0));
    send_item(make_item(OpReport, 16'h0000, 32'd20001, 5'd0, 1'b0));      // gone now
    send_item(make_item(OpReport, 16'h0000, 32'd20002, 5'd1, 1'b1));      // freed
  endtask

  // Register extremes: a limit of one, a zero limit and the largest delay.
  task automatic test_backoff_extremes();
    set_backoff(16'd1, 4'd1);
    send_item(make_item(OpPush, 16'hA5A5, 32'd1000, 5'd0, 1'b0));
    send_item(make_item(OpReport, 16'h0000, 32'd1001, 5'd0, 1'b0));
    // With a zero limit any failure drops the packet.
    set_backoff(16'd0, 4'd0);
    send_item(make_item(OpPush, 16'h5A5A, 32'd2000, 5'd0, 1'b0));
    send_item(make_item(OpReport, 16'h0000, 32'd2001, 5'd0, 1'b0));
    set_backoff(16'hFFFF, 4'd15);
    send_item(make_item(OpPush, 16'h00FF, 32'hFFFF_0000, 5'd0, 1'b0));
    send_item(make_item(OpReport, 16'h0000, 32'hFFFF_0000, 5'd0, 1'b0));
    send_item(make_item(OpScan, 16'h0000, 32'h0001_0000, 5'd0, 1'b0));
    send_item(make_item(OpReport, 16'h0000, 32'h0001_0000, 5'd0, 1'b0));
  endtask

  // Random traffic that mostly behaves like a real link: time moves forward,
  // reports name occupied slots, with some noise mixed in. Halfway through,
  // the sender holds off until the block has delivered everything it owes.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned push_pct,
                                     input int unsigned scan_pct, input int unsigned ok_pct);
    in_item_t    item;
    int unsigned r;
    int unsigned live[$];
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n == n_items / 2) pause_until_drained();
      r = $urandom_range(0, 99);
      if (r < 70) wall_ms += $urandom_range(0, 4000);
      else if (r < 95) wall_ms += $urandom_range(0, 200000);
      else wall_ms = $urandom();
      item.packet_ref = 16'($urandom());
      item.now_ms     = wall_ms;
      item.slot_index = 5'($urandom());
      item.send_ok    = ($urandom_range(0, 99) < ok_pct);
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        item.opcode = OpPush;
      end else if (r < push_pct + scan_pct) begin
        item.opcode = OpScan;
        if ($urandom_range(0, 6) == 0) item.now_ms = $urandom();
      end else if (r < 97) begin
        item.opcode = OpReport;
        live.delete();
        foreach (tbl_valid[i]) if (tbl_valid[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(0, 9) != 0)
          item.slot_index = 5'(live[$urandom_range(0, live.size() - 1)]);
      end else begin
        item.opcode = OpNone;
      end
      send_item(item);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_backoff_extremes();

    // Mostly pushes: the table fills up, full reports appear and scans
    // return requests for many of the slots.
    set_backoff(16'd5000, 4'd5);
    test_random_traffic(110, 70, 15, 50);

    // A random setting with no idle cycles on either side.
    set_backoff(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 15)));
    steady = 1'b1;
    test_random_traffic(100, 35, 30, 50);
    steady = 1'b0;

    // Long backoff and few successes drive the retry counts up deep.
    set_backoff(16'hFFFF, 4'd15);
    test_random_traffic(110, 30, 25, 15);

    // Tiny delays with a low limit: drops and frequent due slots.
    set_backoff(16'd1, 4'd2);
    test_random_traffic(110, 40, 30, 40);

    settle_block();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: retry_tx_slot_queue.f
rtl/rtsq_pkg.sv
rtl/rtsq_cfg.sv
rtl/rtsq_slot_mem.sv
rtl/rtsq_retry.sv
rtl/rtsq_ctrl.sv
rtl/retry_tx_slot_queue.sv
test/testbench.sv
